// ----- rtl/sha_pkg.sv -----
// sha_pkg: shared types, operation codes and constant tables for the sha-256 stream hasher
// used by sha_core and sha256_stream_hasher; no dependencies
`default_nettype none

package sha_pkg;

   localparam logic [1:0] OP_ABSORB        = 2'd0;
   localparam logic [1:0] OP_ABSORB_FINISH = 2'd1;
   localparam logic [1:0] OP_FINISH        = 2'd2;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // control from the sequencer into the compression unit
   typedef struct packed {
      logic       byte_en;
      logic [7:0] byte_data;
      logic       start;
      logic       reinit;
   } core_ctrl_type;

   typedef struct packed {
      logic done;
   } core_stat_type;

   localparam logic [31:0] HASH_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

`default_nettype wire

// ----- rtl/sha_core.sv -----
// sha_core: 512-bit block window, one-round-per-cycle compression unit and chaining state
// depends on sha_pkg
`default_nettype none

module sha_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  sha_pkg::core_ctrl_type      ctrl,
   output sha_pkg::core_stat_type      stat,
   output logic [7:0][31:0]            hash
);

   typedef enum logic [2:0] {
      C_IDLE  = 3'b001,
      C_ROUND = 3'b010,
      C_ADD   = 3'b100
   } core_state_type;

   core_state_type   state_ff, state_in;
   logic [5:0]       round_ff, round_in;
   logic [31:0]      win_ff [16];
   logic [31:0]      win_in [16];
   logic [31:0]      v_ff [8];
   logic [31:0]      v_in [8];
   logic [7:0][31:0] hash_ff, hash_in;

   logic [31:0] big0, big1, ch, maj, t1, t2, sig0, sig1, new_w;

   always_comb begin
      big1 = {v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]}
           ^ {v_ff[4][24:0], v_ff[4][31:25]};
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + big1 + ch + sha_pkg::ROUND_K[round_ff] + win_ff[0];
      big0 = {v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]}
           ^ {v_ff[0][21:0], v_ff[0][31:22]};
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = big0 + maj;
      // message schedule runs in the same window that collected the bytes
      sig0 = {win_ff[1][6:0], win_ff[1][31:7]} ^ {win_ff[1][17:0], win_ff[1][31:18]}
           ^ {3'b000, win_ff[1][31:3]};
      sig1 = {win_ff[14][16:0], win_ff[14][31:17]} ^ {win_ff[14][18:0], win_ff[14][31:19]}
           ^ {10'b0, win_ff[14][31:10]};
      new_w = sig1 + win_ff[9] + sig0 + win_ff[0];
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      win_in   = win_ff;
      v_in     = v_ff;
      hash_in  = hash_ff;

      if (ctrl.byte_en) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = {win_ff[i][23:0], win_ff[i+1][31:24]};
         end
         win_in[15] = {win_ff[15][23:0], ctrl.byte_data};
      end else if (state_ff == C_ROUND) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = new_w;
      end

      case (state_ff)
         C_IDLE: begin
            if (ctrl.start) begin
               for (int i = 0; i < 8; i++) begin
                  v_in[i] = hash_ff[i];
               end
               round_in = '0;
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            round_in = round_ff + 6'd1;
            if (round_ff == sha_pkg::LAST_POS) begin
               state_in = C_ADD;
            end
         end
         C_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + v_ff[i];
            end
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase

      if (ctrl.reinit) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = sha_pkg::HASH_INIT[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         round_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= sha_pkg::HASH_INIT[i];
         end
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         hash_ff  <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      v_ff   <= v_in;
   end

   assign stat.done = (state_ff == C_ADD);
   assign hash      = hash_ff;

endmodule

`default_nettype wire

// ----- rtl/sha256_stream_hasher.sv -----
// sha256_stream_hasher: top level, byte and padding sequencer, bit counter and digest output
// depends on sha_pkg and sha_core
//
//   channel   dir   handshake             payload
//   req       in    req_valid/req_stall   sha_pkg::req_type (operation, data_byte)
//   rsp       out   rsp_valid/rsp_stall   sha_pkg::rsp_type (digest_word, word_index, last_word)
//
// a byte request is accepted only while idle; the 64th byte of a block starts the round
// unit (64 rounds, one per cycle, then the chaining add) and requests stall until it ends
// a finish writes padding one byte per cycle up to the block end, runs one or two
// compressions, then shows eight digest words
// req_stall is high whenever the sequencer is not idle; rsp stalls just hold the word
// synchronous reset returns the chaining state to the initial hash values
`default_nettype none

module sha256_stream_hasher (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  sha_pkg::req_type      req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sha_pkg::rsp_type      rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PAD  = 4'b0010,
      ST_HASH = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic        fin_ff, fin_in;
   logic        mark_ff, mark_in;
   logic        extra_ff, extra_in;
   logic        last_ff, last_in;
   logic [2:0]  idx_ff, idx_in;

   sha_pkg::core_ctrl_type ctrl;
   sha_pkg::core_stat_type stat;
   logic [7:0][31:0]       hash;

   logic       req_acc, rsp_acc, extra_now;
   logic [5:0] len_sel;
   logic [7:0] pad_byte;

   sha_core u_core (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat),
      .hash  (hash)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid && !rsp_stall;

   always_comb begin
      // length bytes go out most significant first
      len_sel   = {3'd7 - fill_ff[2:0], 3'b000};
      extra_now = extra_ff || (mark_ff && (fill_ff >= sha_pkg::LEN_POS));
      if (mark_ff) begin
         pad_byte = sha_pkg::PAD_MARK;
      end else if ((fill_ff >= sha_pkg::LEN_POS) && !extra_ff) begin
         pad_byte = bits_ff[len_sel +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      fin_in   = fin_ff;
      mark_in  = mark_ff;
      extra_in = extra_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      ctrl     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_data.operation)
                  sha_pkg::OP_ABSORB, sha_pkg::OP_ABSORB_FINISH: begin
                     ctrl.byte_en   = 1'b1;
                     ctrl.byte_data = req_data.data_byte;
                     fill_in        = fill_ff + 6'd1;
                     bits_in        = bits_ff + 64'd8;
                     if (req_data.operation == sha_pkg::OP_ABSORB_FINISH) begin
                        fin_in   = 1'b1;
                        mark_in  = 1'b1;
                        state_in = ST_PAD;
                     end
                     if (fill_ff == sha_pkg::LAST_POS) begin
                        ctrl.start = 1'b1;
                        last_in    = 1'b0;
                        state_in   = ST_HASH;
                     end
                  end
                  sha_pkg::OP_FINISH: begin
                     fin_in   = 1'b1;
                     mark_in  = 1'b1;
                     state_in = ST_PAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PAD: begin
            ctrl.byte_en   = 1'b1;
            ctrl.byte_data = pad_byte;
            fill_in        = fill_ff + 6'd1;
            mark_in        = 1'b0;
            if (fill_ff == sha_pkg::LAST_POS) begin
               ctrl.start = 1'b1;
               last_in    = !extra_now;
               extra_in   = 1'b0;
               state_in   = ST_HASH;
            end else begin
               extra_in = extra_now;
            end
         end
         ST_HASH: begin
            if (stat.done) begin
               if (!fin_ff) begin
                  state_in = ST_IDLE;
               end else if (last_ff) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_OUT: begin
            if (rsp_acc) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  ctrl.reinit = 1'b1;
                  bits_in     = '0;
                  fin_in      = 1'b0;
                  last_in     = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         fin_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         extra_ff <= 1'b0;
         last_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         fin_ff   <= fin_in;
         mark_ff  <= mark_in;
         extra_ff <= extra_in;
         last_ff  <= last_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_data.digest_word = hash[idx_ff];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last_word   = (idx_ff == 3'd7);

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// tb: self-checking regression for sha256_stream_hasher, byte-stream sha-256 with padding
// depends on sha_pkg and the rtl top; keeps its own sha-256 model to predict every digest word
`timescale 1ns / 100ps

module tb;

   localparam logic [1:0] OP_UNDEFINED = 2'd3;
   localparam int RANDOM_ITEMS = 230;
   localparam int HOLD_LEN = 400;
   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;
   localparam int EDGE_LENGTHS [10] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   sha_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   sha_pkg::rsp_type rsp_data;

   // predicted hasher state
   logic [31:0] chain_h [8];
   logic [7:0]  block_bytes [64];
   int          fill_level;
   logic [63:0] message_bits;

   sha_pkg::rsp_type expected_words [$];
   int      error_count = 0;
   int      items_sent = 0;
   int      cycle_count = 0;
   int      hold_cycles = 0;
   bit      no_idle = 1'b0;

   sha256_stream_hasher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void sha_compress();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h;
      logic [31:0] t1, t2;
      int t;
      for (t = 0; t < 16; t++)
         w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      for (t = 16; t < 64; t++)
         w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
              + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (t = 0; t < 64; t++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + RK[t] + w[t];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endfunction

   function automatic void start_message();
      chain_h = IV;
      fill_level = 0;
      message_bits = '0;
   endfunction

   function automatic void absorb_byte(logic [7:0] value);
      block_bytes[fill_level] = value;
      fill_level = (fill_level + 1) % 64;
      if (fill_level == 0) begin
         sha_compress();
         message_bits = message_bits + 64'd512;
      end
   endfunction

   function automatic void finish_digest();
      sha_pkg::rsp_type word;
      int i;
      int k;
      i = fill_level;
      block_bytes[i] = 8'h80;
      i++;
      // length field does not fit, spill into an extra block
      if (i > 56) begin
         while (i < 64) begin
            block_bytes[i] = 8'h00;
            i++;
         end
         sha_compress();
         i = 0;
      end
      while (i < 56) begin
         block_bytes[i] = 8'h00;
         i++;
      end
      message_bits = message_bits + 64'(fill_level * 8);
      for (k = 0; k < 8; k++)
         block_bytes[56 + k] = message_bits[63 - 8*k -: 8];
      sha_compress();
      for (k = 0; k < 8; k++) begin
         word.digest_word = chain_h[k];
         word.word_index  = 3'(k);
         word.last_word   = (k == 7);
         expected_words.push_back(word);
      end
      start_message();
   endfunction

   function automatic void hash_request(sha_pkg::req_type r);
      case (r.operation)
         sha_pkg::OP_ABSORB: begin
            absorb_byte(r.data_byte);
         end
         sha_pkg::OP_ABSORB_FINISH: begin
            absorb_byte(r.data_byte);
            finish_digest();
         end
         sha_pkg::OP_FINISH: begin
            finish_digest();
         end
         default: begin
         end
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(logic [1:0] operation, logic [7:0] value);
      sha_pkg::req_type r;
      r.operation = operation;
      r.data_byte = value;
      while (!no_idle && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      hash_request(r);
      if (operation != OP_UNDEFINED)
         items_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(int len, bit tail_finish);
      int n;
      for (n = 0; n < len; n++) begin
         if ($urandom_range(99) < 3)
            send_request(OP_UNDEFINED, 8'($urandom_range(255)));
         send_request((tail_finish && n == len - 1) ? sha_pkg::OP_ABSORB_FINISH
                                                    : sha_pkg::OP_ABSORB,
                      8'($urandom_range(255)));
      end
      if (!tail_finish || len == 0)
         send_request(sha_pkg::OP_FINISH, 8'($urandom_range(255)));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic test_known_vectors();
      send_request(sha_pkg::OP_FINISH, 8'ha5);           // empty message, byte ignored
      send_request(sha_pkg::OP_ABSORB, 8'h61);
      send_request(sha_pkg::OP_ABSORB, 8'h62);
      send_request(OP_UNDEFINED, 8'h5a);                 // must leave the message untouched
      send_request(sha_pkg::OP_ABSORB_FINISH, 8'h63);
      send_request(sha_pkg::OP_ABSORB_FINISH, 8'hff);
      send_request(sha_pkg::OP_ABSORB_FINISH, 8'h00);
   endtask

   task automatic test_reinit_after_finish();
      send_request(sha_pkg::OP_FINISH, 8'h00);
      send_request(sha_pkg::OP_FINISH, 8'hff);
      send_request(OP_UNDEFINED, 8'hff);
      send_request(sha_pkg::OP_FINISH, 8'h3c);
   endtask

   task automatic test_output_hold();
      int m;
      req_valid <= 1'b0;
      @(posedge clock);
      hold_cycles = HOLD_LEN;
      @(negedge clock);
      for (m = 0; m < 3; m++)
         send_message(3, m[0]);
   endtask

   task automatic test_random_messages();
      int first;
      int pick;
      int len;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         no_idle = (items_sent - first >= 100) && (items_sent - first < 170);
         pick = $urandom_range(99);
         if (pick < 25)
            len = EDGE_LENGTHS[$urandom_range(9)];
         else if (pick < 90)
            len = $urandom_range(16);
         else
            len = $urandom_range(130, 66);
         send_message(len, 1'($urandom_range(1)));
      end
      no_idle = 1'b0;
   endtask

   // receiver: random stalls, none while no_idle is set, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else if (no_idle) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 7);
      end
   end

   always @(posedge clock) begin
      sha_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            if (error_count < MAX_REPORTS)
               $display("unexpected digest word %h index %0d last %0b with nothing pending",
                        rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.digest_word !== want.digest_word ||
                rsp_data.word_index !== want.word_index ||
                rsp_data.last_word !== want.last_word) begin
               if (error_count < MAX_REPORTS)
                  $display("digest mismatch: want %h idx %0d last %0b, got %h idx %0d last %0b",
                           want.digest_word, want.word_index, want.last_word,
                           rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sha256_stream_hasher regression: fail");
         $finish;
      end
   end

   initial begin
      start_message();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_known_vectors();
      test_reinit_after_finish();
      test_output_hold();
      test_random_messages();
      drain_results();
      if (error_count == 0)
         $display("sha256_stream_hasher regression: pass");
      else
         $display("sha256_stream_hasher regression: fail");
      $finish;
   end

endmodule

// ----- sha256_stream_hasher.f -----
rtl/sha_pkg.sv
rtl/sha_core.sv
rtl/sha256_stream_hasher.sv
tb/sv/tb.sv
